### hdl/radial_lens_point_warp_defines.svh
// Assertion macros shared by the radial lens point warp RTL.
`ifndef RADIAL_LENS_POINT_WARP_DEFINES_SVH
`define RADIAL_LENS_POINT_WARP_DEFINES_SVH
`ifndef SYNTHESIS
`define RLPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RLPW_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RLPW_ASSERT(lbl, prop, msg)
`define RLPW_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### hdl/rlpw_pkg.sv
// Types and constants of the radial lens point warp.
`default_nettype none
package rlpw_pkg;
    localparam int COORD_W    = 24;
    localparam int RADIUS_W   = 23;
    localparam int STRENGTH_W = 16;
    localparam int DIFF_W     = 25;
    localparam int SQ_W       = 50;
    localparam int ROOT_W     = 25;
    localparam int NUM_W      = 49;
    localparam int QUO_W      = 26;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH = 2'd3;

    localparam logic signed [STRENGTH_W-1:0] STRENGTH_RESET = -16'sd16384;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] warped_x;
        logic signed [COORD_W-1:0] warped_y;
        logic                      inside_lens;
    } out_t;
endpackage
`default_nettype wire

### hdl/rlpw_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module rlpw_isqrt
    import rlpw_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   radicand,
    output logic      [ROOT_W-1:0] root
);
    localparam int REM_W = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [SQ_W-1:0]   data_reg [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   data_in;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  test;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign data_in = radicand;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign data_in = data_reg[k-1];
        end

        assign trial = {rem_in[REM_W-3:0], data_in[SQ_W-1 -: 2]};
        assign test  = {1'b0, root_in, 2'b01};
        assign ge    = (trial >= test);

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
            end
        end

        if (k < ROOT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= ge ? trial - test : trial;
                    data_reg[k] <= {data_in[SQ_W-3:0], 2'b00};
                end
            end
        end
    end

    assign root = root_reg[ROOT_W-1];
endmodule
`default_nettype wire

### hdl/rlpw_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module rlpw_div
    import rlpw_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                en,
    input  wire logic [NUM_W-1:0]    dividend,
    input  wire logic [RADIUS_W-1:0] divisor,
    output logic      [QUO_W-1:0]    quotient
);
    logic [RADIUS_W-1:0] rem_reg [QUO_W-1];
    logic [QUO_W-1:0]    low_reg [QUO_W-1];
    logic [QUO_W-1:0]    quo_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [RADIUS_W-1:0] rem_in;
        logic [QUO_W-1:0]    low_in;
        logic [QUO_W-1:0]    quo_in;
        logic [RADIUS_W:0]   shifted;
        logic [RADIUS_W:0]   diff;
        logic                ge;

        if (k == 0) begin : g_first
            assign rem_in = dividend[NUM_W-1:QUO_W];
            assign low_in = dividend[QUO_W-1:0];
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign shifted = {rem_in, low_in[QUO_W-1]};
        assign ge      = (shifted >= {1'b0, divisor});
        assign diff    = shifted - {1'b0, divisor};

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k] <= {quo_in[QUO_W-2:0], ge};
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= ge ? diff[RADIUS_W-1:0] : shifted[RADIUS_W-1:0];
                    low_reg[k] <= {low_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign quotient = quo_reg[QUO_W-1];
endmodule
`default_nettype wire

### hdl/radial_lens_point_warp.sv
// Top level of the radial lens point warp.
//
//  Port group     Direction  Transfer
//  s_*            in         point request, valid/ready
//  m_*            out        warped point request, valid/ready
//  cfg_*          in         register write, no wait
//
// One request enters per cycle while the output is not stalled.
// The pipeline holds the 25-stage square root and the 26-stage divider.
// Reset clears all valid bits and loads the register reset values.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
`include "radial_lens_point_warp_defines.svh"
module radial_lens_point_warp
    import rlpw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data
);
    localparam int LAT = 4 + ROOT_W + 4 + QUO_W;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic [DIFF_W-1:0]         mag_x;
        logic [DIFF_W-1:0]         mag_y;
        logic                      neg_x;
        logic                      neg_y;
    } sq_side_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      in_lens;
        logic                      neg_x;
        logic                      neg_y;
    } dv_side_t;

    logic signed [COORD_W-1:0]    center_x_reg;
    logic signed [COORD_W-1:0]    center_y_reg;
    logic [RADIUS_W-1:0]          lens_radius_reg;
    logic signed [STRENGTH_W-1:0] strength_reg;

    logic [LAT-1:0] valid_reg;
    logic           en;

    logic signed [COORD_W-1:0] a_px_reg, a_py_reg;
    logic signed [DIFF_W-1:0]  a_dx_reg, a_dy_reg;
    sq_side_t                  b_side_reg;
    logic [SQ_W-1:0]           b_sqx_reg, b_sqy_reg;
    sq_side_t                  c_side_reg;
    logic [SQ_W-1:0]           c_d2_reg;
    sq_side_t                  sq_side_reg [ROOT_W];
    logic [ROOT_W-1:0]         root_dist;
    dv_side_t                  d_side_reg;
    logic [DIFF_W-1:0]         d_magx_reg, d_magy_reg;
    logic [RADIUS_W-1:0]       d_len_reg;
    logic [STRENGTH_W-1:0]     d_mags_reg;
    dv_side_t                  e_side_reg;
    logic [DIFF_W-1:0]         e_magx_reg, e_magy_reg;
    logic [RADIUS_W+STRENGTH_W-1:0] e_prod_reg;
    dv_side_t                  f_side_reg;
    logic [44:0]               f_lox_reg, f_loy_reg;
    logic [43:0]               f_hix_reg, f_hiy_reg;
    dv_side_t                  g_side_reg;
    logic [NUM_W-1:0]          g_numx_reg, g_numy_reg;
    dv_side_t                  dv_side_reg [QUO_W];
    logic [QUO_W-1:0]          quo_x, quo_y;
    out_t                      out_reg;

    logic [DIFF_W-1:0]     b_magx, b_magy;
    logic [STRENGTH_W-1:0] d_mags;
    logic [63:0]           g_sumx, g_sumy;
    logic [COORD_W+3:0]    h_x, h_y;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;
    assign m_valid = valid_reg[LAT-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            lens_radius_reg <= '0;
            strength_reg    <= STRENGTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg    <= cfg_wdata;
                CFG_CENTER_Y: center_y_reg    <= cfg_wdata;
                CFG_RADIUS:   lens_radius_reg <= cfg_wdata[RADIUS_W-1:0];
                CFG_STRENGTH: strength_reg    <= cfg_wdata[STRENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
        end
    end

    assign b_magx = a_dx_reg[DIFF_W-1] ? DIFF_W'(~a_dx_reg + 1'b1) : a_dx_reg;
    assign b_magy = a_dy_reg[DIFF_W-1] ? DIFF_W'(~a_dy_reg + 1'b1) : a_dy_reg;
    assign d_mags = strength_reg[STRENGTH_W-1] ? STRENGTH_W'(~strength_reg + 1'b1)
                                               : strength_reg;

    assign g_sumx = {f_hix_reg, 20'b0} + 64'(f_lox_reg) + {28'b0, lens_radius_reg, 13'b0};
    assign g_sumy = {f_hiy_reg, 20'b0} + 64'(f_loy_reg) + {28'b0, lens_radius_reg, 13'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            a_px_reg <= s_data.point_x;
            a_py_reg <= s_data.point_y;
            a_dx_reg <= {s_data.point_x[COORD_W-1], s_data.point_x}
                      - {center_x_reg[COORD_W-1], center_x_reg};
            a_dy_reg <= {s_data.point_y[COORD_W-1], s_data.point_y}
                      - {center_y_reg[COORD_W-1], center_y_reg};

            b_side_reg.px    <= a_px_reg;
            b_side_reg.py    <= a_py_reg;
            b_side_reg.mag_x <= b_magx;
            b_side_reg.mag_y <= b_magy;
            b_side_reg.neg_x <= a_dx_reg[DIFF_W-1] ^ strength_reg[STRENGTH_W-1];
            b_side_reg.neg_y <= a_dy_reg[DIFF_W-1] ^ strength_reg[STRENGTH_W-1];
            b_sqx_reg        <= b_magx * b_magx;
            b_sqy_reg        <= b_magy * b_magy;

            c_side_reg <= b_side_reg;
            c_d2_reg   <= b_sqx_reg + b_sqy_reg;

            sq_side_reg[0] <= c_side_reg;
            for (int i = 1; i < ROOT_W; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end

            d_side_reg.px      <= sq_side_reg[ROOT_W-1].px;
            d_side_reg.py      <= sq_side_reg[ROOT_W-1].py;
            d_side_reg.neg_x   <= sq_side_reg[ROOT_W-1].neg_x;
            d_side_reg.neg_y   <= sq_side_reg[ROOT_W-1].neg_y;
            d_side_reg.in_lens <= (lens_radius_reg != '0)
                               && (root_dist < {2'b00, lens_radius_reg});
            d_magx_reg         <= sq_side_reg[ROOT_W-1].mag_x;
            d_magy_reg         <= sq_side_reg[ROOT_W-1].mag_y;
            d_len_reg          <= lens_radius_reg - root_dist[RADIUS_W-1:0];
            d_mags_reg         <= d_mags;

            e_side_reg <= d_side_reg;
            e_magx_reg <= d_magx_reg;
            e_magy_reg <= d_magy_reg;
            e_prod_reg <= d_mags_reg * d_len_reg;

            f_side_reg <= e_side_reg;
            f_lox_reg  <= e_prod_reg[19:0] * e_magx_reg;
            f_loy_reg  <= e_prod_reg[19:0] * e_magy_reg;
            f_hix_reg  <= e_prod_reg[38:20] * e_magx_reg;
            f_hiy_reg  <= e_prod_reg[38:20] * e_magy_reg;

            g_side_reg <= f_side_reg;
            g_numx_reg <= g_sumx[NUM_W+13:14];
            g_numy_reg <= g_sumy[NUM_W+13:14];

            dv_side_reg[0] <= g_side_reg;
            for (int i = 1; i < QUO_W; i++) begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    rlpw_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (c_d2_reg),
        .root     (root_dist)
    );

    rlpw_div u_div_x (
        .aclk     (aclk),
        .en       (en),
        .dividend (g_numx_reg),
        .divisor  (lens_radius_reg),
        .quotient (quo_x)
    );

    rlpw_div u_div_y (
        .aclk     (aclk),
        .en       (en),
        .dividend (g_numy_reg),
        .divisor  (lens_radius_reg),
        .quotient (quo_y)
    );

    assign h_x = dv_side_reg[QUO_W-1].neg_x
               ? {{4{dv_side_reg[QUO_W-1].px[COORD_W-1]}}, dv_side_reg[QUO_W-1].px}
                 + {2'b00, quo_x}
               : {{4{dv_side_reg[QUO_W-1].px[COORD_W-1]}}, dv_side_reg[QUO_W-1].px}
                 - {2'b00, quo_x};
    assign h_y = dv_side_reg[QUO_W-1].neg_y
               ? {{4{dv_side_reg[QUO_W-1].py[COORD_W-1]}}, dv_side_reg[QUO_W-1].py}
                 + {2'b00, quo_y}
               : {{4{dv_side_reg[QUO_W-1].py[COORD_W-1]}}, dv_side_reg[QUO_W-1].py}
                 - {2'b00, quo_y};

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.inside_lens <= dv_side_reg[QUO_W-1].in_lens;
            if (!dv_side_reg[QUO_W-1].in_lens) begin
                out_reg.warped_x <= dv_side_reg[QUO_W-1].px;
                out_reg.warped_y <= dv_side_reg[QUO_W-1].py;
            end else begin
                if (h_x[COORD_W+3:COORD_W-1] == '0 || h_x[COORD_W+3:COORD_W-1] == '1) begin
                    out_reg.warped_x <= h_x[COORD_W-1:0];
                end else begin
                    out_reg.warped_x <= h_x[COORD_W+3] ? COORD_MIN : COORD_MAX;
                end
                if (h_y[COORD_W+3:COORD_W-1] == '0 || h_y[COORD_W+3:COORD_W-1] == '1) begin
                    out_reg.warped_y <= h_y[COORD_W-1:0];
                end else begin
                    out_reg.warped_y <= h_y[COORD_W+3] ? COORD_MIN : COORD_MAX;
                end
            end
        end
    end

    `RLPW_ASSERT(a_idle_accepts, !m_valid |-> s_ready, "Input blocked while output empty")
    `RLPW_ASSERT(a_stall_blocks, m_valid && !m_ready |-> !s_ready, "Input taken during stall")
    `RLPW_ASSERT_RST(a_reset_clears, !aresetn |=> valid_reg == '0, "Valid bits survive reset")
endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench of the radial lens point warp with a fixed-point predictor.
module tb
    import rlpw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    in_t s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    radial_lens_point_warp u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Mirror of the lens registers.
    longint lens_cx;
    longint lens_cy;
    longint lens_r;
    longint lens_str;

    in_t point_queue[$];
    out_t warped_expected[$];
    int mismatches;
    logic s_fire;
    logic calm;
    logic long_req;
    logic long_done;
    int send_idle;
    int recv_idle;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint shift_coord(longint p, longint d, longint len);
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        den = longint'(lens_r) << 14;
        num = longint'(lens_str < 0 ? -lens_str : lens_str) * longint'(d < 0 ? -d : d)
              * longint'(len);
        q = (num + (den >> 1)) / den;
        return ((lens_str < 0) != (d < 0)) ? p + longint'(q) : p - longint'(q);
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[COORD_W-1:0];
    endfunction

    function automatic out_t warp_point(in_t p);
        out_t o;
        longint px;
        longint py;
        longint dx;
        longint dy;
        longint root_d;
        px = p.point_x;
        py = p.point_y;
        dx = px - lens_cx;
        dy = py - lens_cy;
        root_d = longint'(int_sqrt(dx * dx + dy * dy));
        o.inside_lens = 1'b0;
        if (lens_r != 0 && root_d < lens_r) begin
            px = shift_coord(px, dx, lens_r - root_d);
            py = shift_coord(py, dy, lens_r - root_d);
            o.inside_lens = 1'b1;
        end
        o.warped_x = clamp_coord(px);
        o.warped_y = clamp_coord(py);
        return o;
    endfunction

    // Sender: presents queued points with random idle bursts.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (send_idle > 0) begin
                send_idle <= send_idle - 1;
                s_valid <= 1'b0;
            end else if (point_queue.size() > 0) begin
                s_data <= point_queue.pop_front();
                s_valid <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0) send_idle <= $urandom_range(1, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (long_req && !long_done) begin
            recv_idle <= 400;
            long_done <= 1'b1;
            m_ready <= 1'b0;
        end else if (recv_idle > 0) begin
            recv_idle <= recv_idle - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) recv_idle <= $urandom_range(1, 6);
        end
    end

    // Monitor: predicts each accepted request and checks each result.
    always @(posedge aclk) begin
        out_t exp_o;
        s_fire <= s_valid && s_ready && aresetn;
        if (aresetn && s_valid && s_ready) warped_expected.push_back(warp_point(s_data));
        if (aresetn && m_valid && m_ready) begin
            if (warped_expected.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("Unexpected result %h", m_data);
            end else begin
                exp_o = warped_expected.pop_front();
                if (m_data.warped_x !== exp_o.warped_x || m_data.warped_y !== exp_o.warped_y
                    || m_data.inside_lens !== exp_o.inside_lens) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("Mismatch: expected x=%0d y=%0d in=%0b, got x=%0d y=%0d in=%0b",
                                 exp_o.warped_x, exp_o.warped_y, exp_o.inside_lens,
                                 m_data.warped_x, m_data.warped_y, m_data.inside_lens);
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[COORD_W-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_lens(longint cx, longint cy, longint r, longint st);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_STRENGTH, st);
        lens_cx = cx;
        lens_cy = cy;
        lens_r = r;
        lens_str = st;
    endtask

    task automatic add_point(longint x, longint y);
        in_t p;
        p.point_x = x[COORD_W-1:0];
        p.point_y = y[COORD_W-1:0];
        point_queue.push_back(p);
    endtask

    task automatic add_random(int n);
        longint ox;
        longint oy;
        longint span;
        for (int i = 0; i < n; i++) begin
            span = (lens_r == 0) ? 1000 : lens_r;
            if ($urandom_range(0, 3) != 0) begin
                ox = longint'($urandom_range(0, 2 * span)) - span;
                oy = longint'($urandom_range(0, 2 * span)) - span;
                add_point(lens_cx + ox, lens_cy + oy);
            end else begin
                add_point(longint'($urandom), longint'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (point_queue.size() > 0 || s_valid || warped_expected.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_data = '0;
        s_fire = 1'b0;
        calm = 1'b0;
        long_req = 1'b0;
        long_done = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        mismatches = 0;
        lens_cx = 0;
        lens_cy = 0;
        lens_r = 0;
        lens_str = -16384;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset values: zero radius passes everything through.
        add_point(8388607, -8388608);
        add_point(0, 0);
        add_random(30);
        drain();

        set_lens(1000 * 256, -2000 * 256, 100 * 256, -16384);
        add_point(lens_cx, lens_cy);
        add_point(lens_cx + lens_r, lens_cy);
        add_point(lens_cx, lens_cy - lens_r);
        add_point(lens_cx + lens_r - 1, lens_cy);
        add_point(lens_cx - 1, lens_cy + 1);
        add_point(lens_cx + 70 * 256, lens_cy + 70 * 256);
        add_point(8388607, 8388607);
        add_point(-8388608, -8388608);
        add_point(8388607, -8388608);
        add_point(-8388608, 8388607);
        add_point(lens_cx + 3, lens_cy - 5);
        add_random(50);
        long_req = 1'b1;
        drain();

        set_lens(8388607, -8388608, 8388607, -32768);
        add_point(8388607, -8388608);
        add_point(0, 0);
        add_random(60);
        drain();

        set_lens(-8388608, 8388607, 1, 32767);
        add_point(-8388608, 8388607);
        add_point(-8388607, 8388607);
        add_random(40);
        drain();

        set_lens(-12345, 6789, 5000 * 256, 0);
        add_point(-12345, 6789);
        add_random(50);
        drain();

        set_lens(8388000, 8388000, 200 * 256, -32768);
        add_random(60);
        drain();

        set_lens(0, 0, 8388607, 32767);
        add_random(60);
        drain();

        calm = 1'b1;
        set_lens(-300000, 250000, 3000 * 256, -20000);
        add_random(60);
        drain();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/rlpw_pkg.sv
hdl/rlpw_isqrt.sv
hdl/rlpw_div.sv
hdl/radial_lens_point_warp.sv
tb/sv/tb.sv
